// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clock, off during reset
`define ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- hw/rtl/bds_pkg.sv -----
package bds_pkg;

   localparam int MAX_DOMAIN = 32;
   localparam int ROW_COUNT  = 32;
   localparam int ROW_AW     = $clog2(ROW_COUNT);
   localparam int VAL_W      = 5;
   localparam int SIZE_W     = 6;

   localparam logic [1:0] OP_QUERY   = 2'd0;
   localparam logic [1:0] OP_SET_MAX = 2'd1;
   localparam logic [1:0] OP_SET_VAL = 2'd2;
   localparam logic [1:0] OP_REM_VAL = 2'd3;

   localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);

   typedef logic [MAX_DOMAIN-1:0] row_type;

   localparam row_type ROW_FULL = '1;

   typedef struct packed {
      logic              en;
      logic [ROW_AW-1:0] addr;
      row_type           data;
   } wr_type;

   typedef struct packed {
      logic [VAL_W-1:0] min_value;
      logic [VAL_W-1:0] max_value;
      logic             is_empty;
      logic             is_fixed;
      logic             range_error;
   } rsp_type;

   // mask of the low n bits, n clamped to 1..MAX_DOMAIN
   function automatic row_type size_mask(logic [SIZE_W-1:0] w);
      logic [SIZE_W:0]     n;
      logic [MAX_DOMAIN:0] wide;
      n = {1'b0, w};
      if (n == '0) n = (SIZE_W+1)'(1);
      if (n > (SIZE_W+1)'(MAX_DOMAIN)) n = (SIZE_W+1)'(MAX_DOMAIN);
      wide = ~({(MAX_DOMAIN+1){1'b1}} << n);
      return wide[MAX_DOMAIN-1:0];
   endfunction

endpackage

// ----- hw/rtl/bds_row_mem.sv -----
module bds_row_mem
   import bds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ROW_AW-1:0] rd_addr,
   output row_type           rd_data,
   input  wr_type            wr
);

   row_type                mem_ff [ROW_COUNT];
   logic [ROW_COUNT-1:0]   valid_ff;
   row_type                rd_data_ff;
   logic                   rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   // unwritten rows read as full domains
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : ROW_FULL;

endmodule

// ----- hw/rtl/bds_update.sv -----
module bds_update
   import bds_pkg::*;
(
   input  logic [1:0]       opcode,
   input  logic [VAL_W-1:0] value,
   input  row_type          cur,
   input  row_type          mask,
   output logic             wr_en,
   output row_type          next_row,
   output rsp_type          rsp
);

   row_type   bit_sel;
   row_type   le_mask;
   row_type   bits;
   logic      err;

   always_comb begin
      bit_sel = row_type'(1) << value;
      le_mask = ~(ROW_FULL << value) | bit_sel;
      err     = (opcode != OP_QUERY) && !mask[value];
      wr_en   = (opcode != OP_QUERY) && !err;

      unique case (opcode)
         OP_SET_MAX: next_row = cur & ~(mask & ~le_mask);
         OP_SET_VAL: next_row = (cur & ~mask) | bit_sel;
         OP_REM_VAL: next_row = cur & ~bit_sel;
         default:    next_row = cur;
      endcase
      if (err) next_row = cur;

      bits = next_row & mask;

      rsp = '0;
      for (int i = MAX_DOMAIN - 1; i >= 0; i--) begin
         if (bits[i]) rsp.min_value = VAL_W'(i);
      end
      for (int i = 0; i < MAX_DOMAIN; i++) begin
         if (bits[i]) rsp.max_value = VAL_W'(i);
      end
      rsp.is_empty    = (bits == '0);
      rsp.is_fixed    = (bits != '0) && ((bits & (bits - row_type'(1))) == '0);
      rsp.range_error = err;
   end

endmodule

// ----- hw/rtl/bitset_domain_store.sv -----
// An accepted request registers its opcode, row and value as the row memory
// reads the row; while busy, the row is modified and written back and the
// result is registered onto the rsp_ ports, with rsp_valid high for one cycle.
// The receiver cannot stall results. No request is accepted while busy, for
// the read then modify-write of the row memory; busy is high for one cycle.
// Reset (synchronous): all rows read as full domains, domain_size is 32.
`include "assert_macros.svh"

module bitset_domain_store
   import bds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_opcode,
   input  logic [ROW_AW-1:0] req_row,
   input  logic [VAL_W-1:0]  req_value,
   output logic              rsp_valid,
   output logic [VAL_W-1:0]  rsp_min_value,
   output logic [VAL_W-1:0]  rsp_max_value,
   output logic              rsp_is_empty,
   output logic              rsp_is_fixed,
   output logic              rsp_range_error,
   input  logic              csr_we,
   input  logic [SIZE_W-1:0] csr_wdata
);

   logic              busy_ff, busy_in;
   logic              rsp_valid_ff, rsp_valid_in;
   row_type           mask_ff, mask_in;
   logic [1:0]        op_ff;
   logic [ROW_AW-1:0] row_ff;
   logic [VAL_W-1:0]  value_ff;
   rsp_type           rsp_ff;

   logic              accept;
   row_type           cur_row;
   row_type           next_row;
   logic              upd_en;
   rsp_type           rsp_next;
   wr_type            wr;

   assign accept       = start && !busy_ff;
   assign busy_in      = accept;
   assign rsp_valid_in = busy_ff;
   assign mask_in      = csr_we ? size_mask(csr_wdata) : mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mask_ff      <= size_mask(SIZE_RESET);
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         mask_ff      <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_opcode;
         row_ff   <= req_row;
         value_ff <= req_value;
      end
      if (busy_ff) begin
         rsp_ff <= rsp_next;
      end
   end

   bds_row_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_addr (req_row),
      .rd_data (cur_row),
      .wr      (wr)
   );

   bds_update u_upd (
      .opcode   (op_ff),
      .value    (value_ff),
      .cur      (cur_row),
      .mask     (mask_ff),
      .wr_en    (upd_en),
      .next_row (next_row),
      .rsp      (rsp_next)
   );

   assign wr.en   = busy_ff && upd_en;
   assign wr.addr = row_ff;
   assign wr.data = next_row;

   assign busy            = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_min_value   = rsp_ff.min_value;
   assign rsp_max_value   = rsp_ff.max_value;
   assign rsp_is_empty    = rsp_ff.is_empty;
   assign rsp_is_fixed    = rsp_ff.is_fixed;
   assign rsp_range_error = rsp_ff.range_error;

   `ASSERT_NEXT(a_busy_one_cycle, busy_ff, !busy_ff)
   `ASSERT_NEXT(a_rsp_follows_busy, busy_ff, rsp_valid_ff)
   `ASSERT_SAME(a_rsp_from_busy, rsp_valid_ff, $past(busy_ff))
   `ASSERT_SAME(a_write_in_busy, wr.en, busy_ff && !accept)

endmodule

// ----- dv/bds_checker.sv -----
module bds_checker
   import bds_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [1:0]        req_opcode,
   input  logic [ROW_AW-1:0] req_row,
   input  logic [VAL_W-1:0]  req_value,
   input  logic              rsp_valid,
   input  logic [VAL_W-1:0]  rsp_min_value,
   input  logic [VAL_W-1:0]  rsp_max_value,
   input  logic              rsp_is_empty,
   input  logic              rsp_is_fixed,
   input  logic              rsp_range_error,
   input  logic              csr_we,
   input  logic [SIZE_W-1:0] csr_wdata,
   output int                mismatch_count,
   output int                status_pending
);

   row_type           domain_model [ROW_COUNT];
   logic [SIZE_W-1:0] size_model;
   rsp_type           expected_status [$];

   // applies the op to the modeled row, returns the expected status
   task automatic apply_domain_op(input logic [1:0] op, input logic [ROW_AW-1:0] r,
                                  input logic [VAL_W-1:0] v, output rsp_type st);
      int                  n;
      int                  cnt;
      logic [MAX_DOMAIN:0] upto;
      row_type             keep;
      row_type             below;
      row_type             onehot;
      row_type             cur;
      row_type             bits;
      n = (size_model == '0) ? 1 :
          (int'(size_model) > MAX_DOMAIN) ? MAX_DOMAIN : int'(size_model);
      upto = (MAX_DOMAIN+1)'(1) << n;
      keep = row_type'(upto - 1'b1);
      upto = (MAX_DOMAIN+1)'(1) << (int'(v) + 1);
      below = row_type'(upto - 1'b1);
      onehot = row_type'(1) << v;
      st = '0;
      cur = domain_model[r];
      if (op != OP_QUERY) begin
         if (int'(v) >= n) begin
            st.range_error = 1'b1;
         end else begin
            case (op)
               OP_SET_MAX: cur = cur & ~(keep & ~below);
               OP_SET_VAL: cur = (cur & ~keep) | onehot;
               OP_REM_VAL: cur = cur & ~onehot;
               default: ;
            endcase
            domain_model[r] = cur;
         end
      end
      bits = cur & keep;
      cnt = 0;
      for (int i = 0; i < MAX_DOMAIN; i++) begin
         if (bits[i]) begin
            if (cnt == 0) st.min_value = VAL_W'(i);
            st.max_value = VAL_W'(i);
            cnt++;
         end
      end
      st.is_empty = (cnt == 0);
      st.is_fixed = (cnt == 1);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type st;
      if (reset) begin
         foreach (domain_model[i]) domain_model[i] = ROW_FULL;
         size_model = SIZE_RESET;
         expected_status.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_status.size() == 0) begin
               $error("response with no request pending");
               mismatch_count++;
            end else begin
               want = expected_status.pop_front();
               check_field("min_value", want.min_value, rsp_min_value);
               check_field("max_value", want.max_value, rsp_max_value);
               check_field("is_empty", want.is_empty, rsp_is_empty);
               check_field("is_fixed", want.is_fixed, rsp_is_fixed);
               check_field("range_error", want.range_error, rsp_range_error);
            end
         end
         if (start && !busy) begin
            apply_domain_op(req_opcode, req_row, req_value, st);
            expected_status.push_back(st);
         end
         if (csr_we) size_model = csr_wdata;
      end
      status_pending = expected_status.size();
   end

endmodule

// ----- dv/tb_bitset_domain_store.sv -----
module tb_bitset_domain_store;
   import bds_pkg::*;

   logic              clock;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_opcode = OP_QUERY;
   logic [ROW_AW-1:0] req_row = '0;
   logic [VAL_W-1:0]  req_value = '0;
   logic              rsp_valid;
   logic [VAL_W-1:0]  rsp_min_value;
   logic [VAL_W-1:0]  rsp_max_value;
   logic              rsp_is_empty;
   logic              rsp_is_fixed;
   logic              rsp_range_error;
   logic              csr_we = 1'b0;
   logic [SIZE_W-1:0] csr_wdata = SIZE_RESET;

   int                mismatch_count;
   int                status_pending;
   int                idle_pct = 0;
   logic [SIZE_W-1:0] size_now = SIZE_RESET;
   logic [SIZE_W-1:0] phase_sizes [10] = '{6'd32, 6'd1, 6'd7, 6'd0, 6'd16,
                                           6'd63, 6'd33, 6'd3, 6'd32, 6'd32};

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   bitset_domain_store uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_row         (req_row),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_min_value   (rsp_min_value),
      .rsp_max_value   (rsp_max_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_fixed    (rsp_is_fixed),
      .rsp_range_error (rsp_range_error),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   bds_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_opcode      (req_opcode),
      .req_row         (req_row),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_min_value   (rsp_min_value),
      .rsp_max_value   (rsp_max_value),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_fixed    (rsp_is_fixed),
      .rsp_range_error (rsp_range_error),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .status_pending  (status_pending)
   );

   task automatic send_request(input logic [1:0] op, input logic [ROW_AW-1:0] r,
                               input logic [VAL_W-1:0] v);
      start <= 1'b1;
      req_opcode <= op;
      req_row <= r;
      req_value <= v;
      @(posedge clock);
      while (busy) @(posedge clock);
      if ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      do @(negedge clock); while (status_pending != 0);
      @(posedge clock);
   endtask

   task automatic write_size(input logic [SIZE_W-1:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      size_now = v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // most requests hit a few rows so their domains narrow down to fixed and empty
   task automatic random_request();
      int                n;
      int                pick;
      logic [1:0]        op;
      logic [ROW_AW-1:0] r;
      logic [VAL_W-1:0]  v;
      n = (size_now == '0) ? 1 :
          (int'(size_now) > MAX_DOMAIN) ? MAX_DOMAIN : int'(size_now);
      pick = $urandom_range(99);
      op = (pick < 15) ? OP_QUERY : (pick < 35) ? OP_SET_MAX :
           (pick < 50) ? OP_SET_VAL : OP_REM_VAL;
      r = ($urandom_range(1) == 0) ? ROW_AW'($urandom_range(31)) : ROW_AW'($urandom_range(7));
      v = ($urandom_range(4) == 0) ? VAL_W'($urandom_range(31)) : VAL_W'($urandom_range(n - 1));
      send_request(op, r, v);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(OP_QUERY, 0, 31);
      send_request(OP_SET_MAX, 0, 31);
      send_request(OP_SET_MAX, 1, 0);
      send_request(OP_SET_VAL, 2, 31);
      send_request(OP_REM_VAL, 2, 31);
      send_request(OP_REM_VAL, 3, 0);
      send_request(OP_QUERY, 3, 0);
      send_request(OP_SET_VAL, 4, 5);
      send_request(OP_SET_MAX, 31, 15);
      send_request(OP_REM_VAL, 31, 15);
      write_size(6'd1);
      send_request(OP_REM_VAL, 5, 1);
      send_request(OP_QUERY, 7, 31);
      send_request(OP_SET_VAL, 5, 0);
      send_request(OP_REM_VAL, 5, 0);
      write_size(6'd0);
      send_request(OP_SET_MAX, 6, 0);
      send_request(OP_REM_VAL, 6, 1);
      send_request(OP_QUERY, 2, 0);
      write_size(6'd63);
      send_request(OP_SET_VAL, 8, 31);
      send_request(OP_QUERY, 5, 0);
      write_size(6'd5);
      send_request(OP_QUERY, 31, 0);
      send_request(OP_SET_MAX, 20, 4);
      send_request(OP_REM_VAL, 20, 5);
      send_request(OP_SET_VAL, 9, 4);
      write_size(6'd32);
      send_request(OP_QUERY, 9, 0);
      send_request(OP_QUERY, 20, 0);

      // idle mix cycles through none, heavy and light sender gaps
      for (int p = 0; p < 10; p++) begin
         write_size((p == 9) ? SIZE_W'($urandom_range(63)) : phase_sizes[p]);
         case (p % 3)
            0: idle_pct = 0;
            1: idle_pct = 88;
            default: idle_pct = 18;
         endcase
         repeat (65) random_request();
      end

      drain();
      repeat (6) @(posedge clock);
      if (mismatch_count == 0 && status_pending == 0) begin
         $display("** bitset_domain_store: PASSED **");
      end else begin
         $display("** bitset_domain_store: FAILED **");
      end
      $finish;
   end

   initial begin
      #3000000;
      $display("** bitset_domain_store: FAILED **");
      $finish;
   end

endmodule
